// ===== rtl/alpha_edge_color_dilation_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the alpha edge colour dilation block
// Shared assertion forms, each a clocked implication with a reset disable.
// ----------------------------------------------------------------------------
`ifndef ALPHA_EDGE_COLOR_DILATION_TOP_DEFINES_SVH
`define ALPHA_EDGE_COLOR_DILATION_TOP_DEFINES_SVH

// Overlapping implication: consequent checked in the same cycle
`define AECD_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("aecd assertion failed");

// Non-overlapping implication: consequent checked in the next cycle
`define AECD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("aecd assertion failed");

`endif

// ===== rtl/aecd_pkg.sv =====
// ----------------------------------------------------------------------------
// aecd_pkg
// Shared codes, reset values and control types of the dilation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aecd_pkg;

  // Default build sizes
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int PASS_PAIRS_DEF = 5;

  // Command codes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CHANS  = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  // Register reset values
  localparam logic [8:0] WIDTH_RST  = 9'd256;
  localparam logic [8:0] HEIGHT_RST = 9'd256;
  localparam logic [2:0] CHANS_RST  = 3'd4;
  localparam logic [7:0] THRESH_RST = 8'd30;

  // Alpha written into a filled pixel
  localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

  // Source store selection for a pass
  localparam logic [1:0] SRC_SOURCE = 2'd0;
  localparam logic [1:0] SRC_A      = 2'd1;
  localparam logic [1:0] SRC_B      = 2'd2;

  // Pass engine control towards the stores
  typedef struct packed {
    logic       busy;
    logic       done;
    logic       we;
    logic       dst_b;
    logic [1:0] src_sel;
  } eng_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/aecd_in_if.sv =====
// ----------------------------------------------------------------------------
// aecd_in_if
// Command channel: opcode, pixel position and channel bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface aecd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] pixel_index;
  logic [7:0]  chan0;
  logic [7:0]  chan1;
  logic [7:0]  chan2;
  logic [7:0]  chan3;

  modport source (output valid, opcode, pixel_index, chan0, chan1, chan2, chan3,
                  input ready);
  modport sink (input valid, opcode, pixel_index, chan0, chan1, chan2, chan3,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/aecd_out_if.sv =====
// ----------------------------------------------------------------------------
// aecd_out_if
// Result channel: pixel position and returned channel bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface aecd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_index;
  logic [7:0]  out_chan0;
  logic [7:0]  out_chan1;
  logic [7:0]  out_chan2;
  logic [7:0]  out_chan3;

  modport source (output valid, out_index, out_chan0, out_chan1, out_chan2,
                  out_chan3, input ready);
  modport sink (input valid, out_index, out_chan0, out_chan1, out_chan2,
                out_chan3, output ready);
endinterface

`default_nettype wire

// ===== rtl/aecd_ram.sv =====
// ----------------------------------------------------------------------------
// aecd_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aecd_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 65536,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/aecd_pass.sv =====
// ----------------------------------------------------------------------------
// aecd_pass
// Dilation sequencer: walks every pixel of every pass, reads the centre, and if
// it is not opaque reads neighbours in turn until one is; writes other store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aecd_pass #(
  parameter  int MAX_WIDTH  = aecd_pkg::MAX_WIDTH_DEF,
  parameter  int MAX_HEIGHT = aecd_pkg::MAX_HEIGHT_DEF,
  parameter  int PASS_PAIRS = aecd_pkg::PASS_PAIRS_DEF,
  localparam int DW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DW-1:0]     w,
  input  wire logic [HW-1:0]     h,
  input  wire logic              nch3,
  input  wire logic [7:0]        thr,
  input  wire logic [31:0]       rd_data,
  output aecd_pkg::eng_ctl_t     ctl,
  output logic      [AW-1:0]     rd_addr,
  output logic      [AW-1:0]     wr_addr,
  output logic      [31:0]       wr_data
);

  localparam int NP = 2 * PASS_PAIRS + 1;
  localparam int PW = $clog2(NP + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CEN  = 2'd1;
  localparam logic [1:0] S_CHKC = 2'd2;
  localparam logic [1:0] S_CHKN = 2'd3;

  localparam logic [1:0] NB_UP    = 2'd0;
  localparam logic [1:0] NB_LEFT  = 2'd1;
  localparam logic [1:0] NB_RIGHT = 2'd2;
  localparam logic [1:0] NB_DOWN  = 2'd3;

  logic [1:0]    state;
  logic [DW-1:0] x;
  logic [HW-1:0] y;
  logic [AW-1:0] m;
  logic [PW-1:0] pass;
  logic [1:0]    nb;
  logic [31:0]   px;

  logic          x_last, y_last, pass_last;
  logic [AW-1:0] w_a;
  logic [1:0]    nb_next;
  logic [7:0]    alpha;
  logic          opaque;
  logic [31:0]   merged;

  assign x_last    = (x == w - 1'b1);
  assign y_last    = (y == h - 1'b1);
  assign pass_last = (pass == PW'(NP - 1));
  assign w_a       = AW'(32'(w));
  assign nb_next   = (state == S_CHKC) ? NB_UP : nb + 2'd1;

  // Neighbour address with edge clamping
  always_comb begin
    case (state)
      S_CEN: rd_addr = m;
      default: begin
        case (nb_next)
          NB_UP:    rd_addr = (y == '0) ? m : m - w_a;
          NB_LEFT:  rd_addr = (x == '0) ? m : m - 1'b1;
          NB_RIGHT: rd_addr = x_last ? m : m + 1'b1;
          NB_DOWN:  rd_addr = y_last ? m : m + w_a;
          default:  rd_addr = m;
        endcase
      end
    endcase
  end

  // Opacity of the word just read, and the fill value
  assign alpha  = nch3 ? rd_data[23:16] : rd_data[31:24];
  assign opaque = (alpha > thr);
  assign merged = nch3 ? {px[31:24], aecd_pkg::OPAQUE_ALPHA, rd_data[15:0]}
                       : {aecd_pkg::OPAQUE_ALPHA, rd_data[23:0]};

  // Store control
  always_comb begin
    ctl.busy    = (state != S_IDLE);
    ctl.we      = ((state == S_CHKC) && opaque) ||
                  ((state == S_CHKN) && (opaque || (nb == NB_DOWN)));
    ctl.done    = ctl.we && x_last && y_last && pass_last;
    ctl.dst_b   = pass[0];
    ctl.src_sel = (pass == '0) ? aecd_pkg::SRC_SOURCE :
                  (pass[0] ? aecd_pkg::SRC_A : aecd_pkg::SRC_B);
  end

  assign wr_addr = m;
  assign wr_data = (state == S_CHKC) ? rd_data : (opaque ? merged : px);

  // Sequence pixels and passes
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      x     <= '0;
      y     <= '0;
      m     <= '0;
      pass  <= '0;
      nb    <= NB_UP;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CEN;
            x     <= '0;
            y     <= '0;
            m     <= '0;
            pass  <= '0;
          end
        end
        S_CEN: begin
          state <= S_CHKC;
        end
        S_CHKC, S_CHKN: begin
          if (state == S_CHKC) begin
            px <= rd_data;
          end
          if (ctl.we) begin
            state <= S_CEN;
            if (x_last) begin
              x <= '0;
              if (y_last) begin
                y <= '0;
                m <= '0;
                if (pass_last) begin
                  state <= S_IDLE;
                  pass  <= '0;
                end else begin
                  pass <= pass + 1'b1;
                end
              end else begin
                y <= y + 1'b1;
                m <= m + 1'b1;
              end
            end else begin
              x <= x + 1'b1;
              m <= m + 1'b1;
            end
          end else begin
            state <= S_CHKN;
            nb    <= nb_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/alpha_edge_color_dilation_top.sv =====
// ----------------------------------------------------------------------------
// alpha_edge_color_dilation_top
// Image store with alpha edge colour dilation and an APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command per transaction: load a pixel, run the dilation,
//   or read a pixel back. res returns one transaction per read command.
//   A load is written as it is accepted; the next command may follow directly.
//   A read passes through the pending-read flag into the result register; no
//   new command is taken while a read is pending.
//   A run walks every pixel 1+2*PASS_PAIRS times. Each pixel reads the centre
//   word and then, if it is not opaque, one neighbour at a time (up to four)
//   until one is opaque, as the single read port of the pass's source store
//   supplies one word a cycle. cmd stays low during a run.
//   While res is stalled the result holds and no command is taken.
//   Reset sets the registers to their defaults and clears the run flag; the
//   image stores are undefined until loaded and need no clearing pass.
//   Registers (APB, byte address 4*i): width, height, channels, threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alpha_edge_color_dilation_top #(
  parameter  int MAX_WIDTH  = aecd_pkg::MAX_WIDTH_DEF,
  parameter  int MAX_HEIGHT = aecd_pkg::MAX_HEIGHT_DEF,
  parameter  int PASS_PAIRS = aecd_pkg::PASS_PAIRS_DEF,
  localparam int DW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  aecd_in_if.sink          cmd,
  aecd_out_if.source       res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [8:0] cfg_w, cfg_h;
  logic [2:0] cfg_ch;
  logic [7:0] cfg_thr;

  logic [DW-1:0]    eff_w;
  logic [HW-1:0]    eff_h;
  logic [DW+HW-1:0] npix;
  logic             nch3;

  logic acc, in_range, load_we;
  logic dilated_valid, rd_pend, rd_hit;
  logic [15:0] rd_idx;
  logic [AW-1:0] cmd_addr;

  aecd_pkg::eng_ctl_t ctl;
  logic [AW-1:0] eng_raddr, eng_waddr;
  logic [31:0]   eng_wdata, eng_rdata;

  logic [31:0] src_q, a_q, b_q, col;
  logic        out_valid;
  logic [15:0] out_index;
  logic [7:0]  out_c0, out_c1, out_c2, out_c3;

  // Register writes
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w   <= aecd_pkg::WIDTH_RST;
      cfg_h   <= aecd_pkg::HEIGHT_RST;
      cfg_ch  <= aecd_pkg::CHANS_RST;
      cfg_thr <= aecd_pkg::THRESH_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        aecd_pkg::REG_WIDTH:  cfg_w   <= pwdata[8:0];
        aecd_pkg::REG_HEIGHT: cfg_h   <= pwdata[8:0];
        aecd_pkg::REG_CHANS:  cfg_ch  <= pwdata[2:0];
        aecd_pkg::REG_THRESH: cfg_thr <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[3:2])
      aecd_pkg::REG_WIDTH:  prdata = 32'(cfg_w);
      aecd_pkg::REG_HEIGHT: prdata = 32'(cfg_h);
      aecd_pkg::REG_CHANS:  prdata = 32'(cfg_ch);
      aecd_pkg::REG_THRESH: prdata = 32'(cfg_thr);
      default:              prdata = '0;
    endcase
  end

  // Saturate geometry into the supported range
  assign eff_w = (cfg_w == '0) ? DW'(1) :
                 ((32'(cfg_w) > MAX_WIDTH) ? DW'(MAX_WIDTH) : DW'(cfg_w));
  assign eff_h = (cfg_h == '0) ? HW'(1) :
                 ((32'(cfg_h) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_h));
  assign npix  = (DW+HW)'(32'(eff_w) * 32'(eff_h));
  assign nch3  = (cfg_ch <= 3'd3);

  // Command handshake
  assign cmd.ready = !ctl.busy && !rd_pend && (!out_valid || res.ready);
  assign acc       = cmd.valid && cmd.ready;
  assign in_range  = (32'(cmd.pixel_index) < 32'(npix));
  assign load_we   = acc && (cmd.opcode == aecd_pkg::OP_LOAD) && in_range;
  assign cmd_addr  = AW'(32'(cmd.pixel_index));

  // Pass engine
  aecd_pass #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .PASS_PAIRS(PASS_PAIRS)
  ) u_pass (
    .clk    (clk),
    .rst    (rst),
    .start  (acc && (cmd.opcode == aecd_pkg::OP_RUN)),
    .w      (eff_w),
    .h      (eff_h),
    .nch3   (nch3),
    .thr    (cfg_thr),
    .rd_data(eng_rdata),
    .ctl    (ctl),
    .rd_addr(eng_raddr),
    .wr_addr(eng_waddr),
    .wr_data(eng_wdata)
  );

  // Loaded image
  aecd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_src (
    .clk  (clk),
    .we   (load_we),
    .waddr(cmd_addr),
    .wdata({cmd.chan3, cmd.chan2, cmd.chan1, cmd.chan0}),
    .raddr(ctl.busy ? eng_raddr : cmd_addr),
    .rdata(src_q)
  );

  // Work store A, final pass result
  aecd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_work_a (
    .clk  (clk),
    .we   (ctl.we && !ctl.dst_b),
    .waddr(eng_waddr),
    .wdata(eng_wdata),
    .raddr(ctl.busy ? eng_raddr : cmd_addr),
    .rdata(a_q)
  );

  // Work store B
  aecd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_work_b (
    .clk  (clk),
    .we   (ctl.we && ctl.dst_b),
    .waddr(eng_waddr),
    .wdata(eng_wdata),
    .raddr(eng_raddr),
    .rdata(b_q)
  );

  // Pick the pass source word
  always_comb begin
    case (ctl.src_sel)
      aecd_pkg::SRC_SOURCE: eng_rdata = src_q;
      aecd_pkg::SRC_A:      eng_rdata = a_q;
      default:              eng_rdata = b_q;
    endcase
  end

  // Track run state and pending reads
  always_ff @(posedge clk) begin
    if (rst) begin
      dilated_valid <= 1'b0;
      rd_pend       <= 1'b0;
    end else begin
      if (ctl.done) begin
        dilated_valid <= 1'b1;
      end else if (load_we) begin
        dilated_valid <= 1'b0;
      end
      rd_pend <= acc && (cmd.opcode == aecd_pkg::OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_idx <= cmd.pixel_index;
      rd_hit <= in_range;
    end
  end

  // Result register
  assign col = dilated_valid ? a_q : src_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pend) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      out_index <= rd_idx;
      out_c0    <= rd_hit ? col[7:0] : 8'd0;
      out_c1    <= rd_hit ? col[15:8] : 8'd0;
      out_c2    <= !rd_hit ? 8'd0 : (nch3 ? src_q[23:16] : col[23:16]);
      out_c3    <= (!rd_hit || nch3) ? 8'd0 : src_q[31:24];
    end
  end

  assign res.valid     = out_valid;
  assign res.out_index = out_index;
  assign res.out_chan0 = out_c0;
  assign res.out_chan1 = out_c1;
  assign res.out_chan2 = out_c2;
  assign res.out_chan3 = out_c3;

endmodule

`default_nettype wire

// ===== rtl/aecd_chk.sv =====
// ----------------------------------------------------------------------------
// aecd_chk
// Port-level checks of the dilation block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "alpha_edge_color_dilation_top_defines.svh"

module aecd_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cmd_valid,
  input wire logic        cmd_ready,
  input wire logic [1:0]  cmd_opcode,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [15:0] res_index
);

  logic cmd_acc;
  assign cmd_acc = cmd_valid && cmd_ready;

  // A stalled result holds
  `AECD_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_index))
  // Every read transaction returns a result via the pending-read flag
  `AECD_ASSERT_SAME(a_read_result, clk, rst, cmd_acc && (cmd_opcode == aecd_pkg::OP_READ), ##2 res_valid)
  // The result register is free right after any command
  `AECD_ASSERT_NEXT(a_out_free, clk, rst, cmd_acc, !res_valid)
  // A run blocks further commands
  `AECD_ASSERT_NEXT(a_run_busy, clk, rst, cmd_acc && (cmd_opcode == aecd_pkg::OP_RUN), !cmd_ready)

endmodule

bind alpha_edge_color_dilation_top aecd_chk u_aecd_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .cmd_opcode(cmd.opcode),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_index (res.out_index)
);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the alpha edge colour dilation block. Loads images
// of several shapes and register settings, mixes loads, runs and reads with
// random gaps on both channels, and checks every read transaction against a
// behavioural dilation predictor kept in the bench.
// ----------------------------------------------------------------------------

module tb_top;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int PIX_MAX = aecd_pkg::MAX_WIDTH_DEF * aecd_pkg::MAX_HEIGHT_DEF;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] idx;
    logic [7:0]  c0, c1, c2, c3;
  } pix_cmd_t;

  typedef struct packed {
    logic [15:0] idx;
    logic [7:0]  c0, c1, c2, c3;
  } pix_res_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  aecd_in_if cmd ();
  aecd_out_if res ();

  alpha_edge_color_dilation_top dut (
    .clk(clk), .rst(rst), .cmd(cmd), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state
  logic [8:0] cur_width;
  logic [8:0] cur_height;
  logic [2:0] cur_chans;
  logic [7:0] cur_thresh;
  logic [31:0] src_img [PIX_MAX];
  logic [31:0] work_a [PIX_MAX];
  logic [31:0] work_b [PIX_MAX];
  logic dilated;

  pix_cmd_t pending_cmds [$];
  pix_res_t expected_pixels [$];
  int errors;
  int gap_left;
  int quiet_phase;
  int idle_cycles;
  logic bus_hit;

  function automatic int eff_w();
    return (cur_width < 1) ? 1 :
           (cur_width > aecd_pkg::MAX_WIDTH_DEF) ? aecd_pkg::MAX_WIDTH_DEF : cur_width;
  endfunction

  function automatic int eff_h();
    return (cur_height < 1) ? 1 :
           (cur_height > aecd_pkg::MAX_HEIGHT_DEF) ? aecd_pkg::MAX_HEIGHT_DEF : cur_height;
  endfunction

  function automatic int eff_ch();
    return (cur_chans <= 3) ? 3 : 4;
  endfunction

  function automatic logic [31:0] fetch_word(int sel, int m);
    case (sel)
      0: return src_img[m];
      1: return work_a[m];
      default: return work_b[m];
    endcase
  endfunction

  // One dilation pass; sel 0 source, 1 store A, 2 store B
  task automatic dilate_pass(int from_sel, int to_sel);
    int w, h, a_sh, nx, ny, k;
    logic [31:0] px, nb, r, cmask;
    int dx [4];
    int dy [4];
    dx = '{0, -1, 1, 0};
    dy = '{-1, 0, 0, 1};
    w = eff_w();
    h = eff_h();
    a_sh = (eff_ch() - 1) * 8;
    cmask = (eff_ch() == 3) ? 32'h0000FFFF : 32'h00FFFFFF;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        px = fetch_word(from_sel, y * w + x);
        r = px;
        if (((px >> a_sh) & 8'hFF) <= cur_thresh) begin
          for (int c = 0; c < 4; c++) begin
            nx = x + dx[c];
            ny = y + dy[c];
            if (nx < 0) nx = 0;
            if (nx > w - 1) nx = w - 1;
            if (ny < 0) ny = 0;
            if (ny > h - 1) ny = h - 1;
            k = ny * w + nx;
            nb = fetch_word(from_sel, k);
            if (((nb >> a_sh) & 8'hFF) > cur_thresh) begin
              r = (px & ~cmask) | (nb & cmask);
              r = (r & ~(32'hFF << a_sh)) | (32'(aecd_pkg::OPAQUE_ALPHA) << a_sh);
              break;
            end
          end
        end
        if (to_sel == 1) work_a[y * w + x] = r;
        else work_b[y * w + x] = r;
      end
    end
  endtask

  // Update the image model for one accepted transaction, queue any read result
  task automatic predict_pixel(pix_cmd_t it);
    int npix;
    logic [31:0] orig, col;
    pix_res_t e;
    npix = eff_w() * eff_h();
    case (it.op)
      aecd_pkg::OP_LOAD: begin
        if (it.idx < npix) begin
          src_img[it.idx] = {it.c3, it.c2, it.c1, it.c0};
          dilated = 1'b0;
        end
      end
      aecd_pkg::OP_RUN: begin
        dilate_pass(0, 1);
        for (int i = 0; i < aecd_pkg::PASS_PAIRS_DEF; i++) begin
          dilate_pass(1, 2);
          dilate_pass(2, 1);
        end
        dilated = 1'b1;
      end
      aecd_pkg::OP_READ: begin
        e = '0;
        e.idx = it.idx;
        if (it.idx < npix) begin
          orig = src_img[it.idx];
          col = dilated ? work_a[it.idx] : orig;
          e.c0 = col[7:0];
          e.c1 = col[15:8];
          if (eff_ch() == 3) begin
            e.c2 = orig[23:16];
          end else begin
            e.c2 = col[23:16];
            e.c3 = orig[31:24];
          end
        end
        expected_pixels.push_back(e);
      end
      default: ;
    endcase
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Command driver: accept, then present the next pending transaction
  initial begin
    cmd.valid = 1'b0;
    cmd.opcode = aecd_pkg::OP_LOAD;
    cmd.pixel_index = '0;
    cmd.chan0 = '0;
    cmd.chan1 = '0;
    cmd.chan2 = '0;
    cmd.chan3 = '0;
    res.ready = 1'b0;
    gap_left = 0;
    quiet_phase = 0;
  end

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase != 0 || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    pix_cmd_t nxt;
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (!cmd.valid || cmd.ready) begin
      if (cmd.valid && cmd.ready) begin
        predict_pixel({cmd.opcode, cmd.pixel_index, cmd.chan0, cmd.chan1,
                       cmd.chan2, cmd.chan3});
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        cmd.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        nxt = pending_cmds.pop_front();
        cmd.valid <= 1'b1;
        cmd.opcode <= nxt.op;
        cmd.pixel_index <= nxt.idx;
        cmd.chan0 <= nxt.c0;
        cmd.chan1 <= nxt.c1;
        cmd.chan2 <= nxt.c2;
        cmd.chan3 <= nxt.c3;
        gap_left <= random_gap();
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each transaction with the oldest expectation
  always @(posedge clk) begin
    pix_res_t e;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result transaction, index %0d", res.out_index);
          errors++;
        end else begin
          e = expected_pixels.pop_front();
          if (res.out_index !== e.idx) begin
            $error("out_index: expected %0d, got %0d", e.idx, res.out_index);
            errors++;
          end
          if (res.out_chan0 !== e.c0) begin
            $error("out_chan0: expected %0d, got %0d", e.c0, res.out_chan0);
            errors++;
          end
          if (res.out_chan1 !== e.c1) begin
            $error("out_chan1: expected %0d, got %0d", e.c1, res.out_chan1);
            errors++;
          end
          if (res.out_chan2 !== e.c2) begin
            $error("out_chan2: expected %0d, got %0d", e.c2, res.out_chan2);
            errors++;
          end
          if (res.out_chan3 !== e.c3) begin
            $error("out_chan3: expected %0d, got %0d", e.c3, res.out_chan3);
            errors++;
          end
        end
      end
      res.ready <= (quiet_phase != 0) ? 1'b1 : (random_gap() == 0);
    end
  end

  // Watchdog: count cycles with no transaction on any port
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready) || bus_hit) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Setup cycle and access cycle, then the bus is left idle
  task automatic reg_write(logic [1:0] index, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    bus_hit <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    bus_hit <= 1'b0;
    case (index)
      aecd_pkg::REG_WIDTH:  cur_width = value[8:0];
      aecd_pkg::REG_HEIGHT: cur_height = value[8:0];
      aecd_pkg::REG_CHANS:  cur_chans = value[2:0];
      default:              cur_thresh = value[7:0];
    endcase
    @(posedge clk);
  endtask

  // Alpha biased towards the threshold and the extremes
  function automatic logic [7:0] pick_alpha(logic [7:0] thr);
    case ($urandom_range(0, 4))
      0: return 8'd0;
      1: return 8'hFF;
      2: return thr;
      3: return thr + 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pix_cmd_t make_load(int idx, logic [7:0] thr);
    pix_cmd_t it;
    it.op = aecd_pkg::OP_LOAD;
    it.idx = 16'(idx);
    it.c0 = 8'($urandom);
    it.c1 = 8'($urandom);
    it.c2 = 8'($urandom);
    it.c3 = 8'($urandom);
    if (eff_ch() == 3) it.c2 = pick_alpha(thr);
    else it.c3 = pick_alpha(thr);
    return it;
  endfunction

  function automatic pix_cmd_t make_op(logic [1:0] op, int idx);
    pix_cmd_t it;
    it = '0;
    it.op = op;
    it.idx = 16'(idx);
    return it;
  endfunction

  // Hold until the block has drained and any run has finished
  task automatic drain();
    while (pending_cmds.size() > 0 || cmd.valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (eff_w() * eff_h() * 6 * (1 + 2 * aecd_pkg::PASS_PAIRS_DEF) + 50) @(posedge clk);
  endtask

  // One phase: set registers, reload the whole image if asked, then a random mix
  task automatic run_phase(logic [8:0] w, logic [8:0] h, logic [2:0] ch,
                           logic [7:0] thr, int nitems, bit reload);
    int npix, r;
    reg_write(aecd_pkg::REG_WIDTH, 32'(w));
    reg_write(aecd_pkg::REG_HEIGHT, 32'(h));
    reg_write(aecd_pkg::REG_CHANS, 32'(ch));
    reg_write(aecd_pkg::REG_THRESH, 32'(thr));
    quiet_phase = ($urandom_range(0, 3) == 0);
    npix = eff_w() * eff_h();
    if (reload)
      for (int m = 0; m < npix; m++) pending_cmds.push_back(make_load(m, thr));
    for (int n = 0; n < nitems; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        pending_cmds.push_back(make_load($urandom_range(0, npix - 1), thr));
      end else if (r < 46) begin
        pending_cmds.push_back(make_load($urandom_range(npix, 65535), thr));
      end else if (r < 84) begin
        pending_cmds.push_back(make_op(aecd_pkg::OP_READ, $urandom_range(0, npix - 1)));
      end else if (r < 91) begin
        pending_cmds.push_back(make_op(aecd_pkg::OP_READ, $urandom_range(npix, 65535)));
      end else if (r < 97) begin
        pending_cmds.push_back(make_op(aecd_pkg::OP_RUN, $urandom));
      end else begin
        pending_cmds.push_back(make_load($urandom, thr) | 48'h0 | {2'b11, 48'h0});
      end
    end
    drain();
  endtask

  initial begin
    pix_cmd_t it;
    errors = 0;
    dilated = 1'b0;
    cur_width = aecd_pkg::WIDTH_RST;
    cur_height = aecd_pkg::HEIGHT_RST;
    cur_chans = aecd_pkg::CHANS_RST;
    cur_thresh = aecd_pkg::THRESH_RST;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    bus_hit = 1'b0;
    idle_cycles = 0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: 3x3 image, read before run, run, load after run, stray codes
    reg_write(aecd_pkg::REG_WIDTH, 32'd3);
    reg_write(aecd_pkg::REG_HEIGHT, 32'd3);
    for (int m = 0; m < 9; m++) begin
      it = make_load(m, aecd_pkg::THRESH_RST);
      it.c3 = (m == 4) ? 8'hFF : (m == 8) ? 8'd31 : (m == 0) ? 8'd30 : 8'd0;
      pending_cmds.push_back(it);
    end
    pending_cmds.push_back(make_op(aecd_pkg::OP_READ, 0));
    pending_cmds.push_back(make_op(aecd_pkg::OP_RUN, 0));
    for (int m = 0; m < 9; m++) pending_cmds.push_back(make_op(aecd_pkg::OP_READ, m));
    pending_cmds.push_back(make_op(aecd_pkg::OP_READ, 16'hFFFF));
    it = make_load(16'hFFFF, 8'd0);
    pending_cmds.push_back(it);
    it = make_load(2, 8'd0);
    it.op = OP_IGNORED;
    pending_cmds.push_back(it);
    pending_cmds.push_back(make_op(aecd_pkg::OP_READ, 2));
    pending_cmds.push_back(make_load(1, 8'd0));
    pending_cmds.push_back(make_op(aecd_pkg::OP_READ, 1));
    drain();
    // Registers changed between a run and a read: same size, new mode
    pending_cmds.push_back(make_op(aecd_pkg::OP_RUN, 0));
    drain();
    run_phase(9'd3, 9'd3, 3'd3, 8'd200, 6, 1'b0);

    // Extremes and saturation of the registers; the later row and column
    // shapes reuse the 256 pixels loaded by the wide phase
    run_phase(9'd0, 9'd0, 3'd0, 8'd0, 20, 1'b1);
    run_phase(9'd511, 9'd1, 3'd7, 8'd255, 20, 1'b1);
    run_phase(9'd1, 9'd300, 3'd3, 8'd128, 20, 1'b0);
    run_phase(9'd256, 9'd1, 3'd4, 8'd30, 20, 1'b0);
    run_phase(9'd4, 9'd4, 3'd2, 8'd30, 20, 1'b1);

    // Random shapes, all small
    for (int p = 0; p < 2; p++)
      run_phase(9'($urandom_range(1, 8)), 9'($urandom_range(1, 8)),
                3'($urandom_range(0, 7)), 8'($urandom), 15, 1'b1);

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/aecd_pkg.sv
rtl/aecd_in_if.sv
rtl/aecd_out_if.sv
rtl/aecd_ram.sv
rtl/aecd_pass.sv
rtl/alpha_edge_color_dilation_top.sv
rtl/aecd_chk.sv
test/tb_top.sv
